// ===== sv/bcim_pkg.sv =====
// Package: widths, payload structs and register codes for the block-cyclic index map.
`default_nettype none
package bcim_pkg;

  localparam int IdxW    = 31;
  localparam int NbW     = 7;
  localparam int GridW   = 12;
  localparam int RankW   = 24;
  localparam int LocW    = 62;
  localparam int CfgAddrW = 3;
  localparam int DivLat  = 2 * IdxW;
  localparam int PostLat = 4;
  localparam int Latency = DivLat + PostLat;

  typedef enum logic [CfgAddrW-1:0] {
    REG_MATRIX_SIZE = 3'd0,
    REG_BLOCK_SIZE  = 3'd1,
    REG_GRID_ROWS   = 3'd2,
    REG_GRID_COLS   = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [IdxW-1:0] global_row;
    logic [IdxW-1:0] global_col;
  } bcim_in_t;

  typedef struct packed {
    logic [RankW-1:0] owner_rank;
    logic [LocW-1:0]  local_index;
    logic             index_error;
  } bcim_out_t;

  // effective (zero taken as one) distribution settings
  typedef struct packed {
    logic [NbW-1:0]   nb;
    logic [GridW-1:0] npc;
  } bcim_cfg_t;

  // divider outputs handed to the assembly stages
  typedef struct packed {
    logic             valid;
    logic             err;
    logic [IdxW-1:0]  qq_r;
    logic [NbW-1:0]   rem_r;
    logic [GridW-1:0] pr;
    logic [IdxW-1:0]  qq_c;
    logic [NbW-1:0]   rem_c;
    logic [GridW-1:0] pc;
    logic [IdxW-1:0]  bq;
    logic [GridW-1:0] extra;
    logic [NbW-1:0]   rem_n;
  } bcim_mid_t;

endpackage
`default_nettype wire

// ===== sv/bcim_div_pipe.sv =====
// Restoring divider, one quotient bit per register stage, with side data.
`default_nettype none
module bcim_div_pipe
  import bcim_pkg::*;
#(
  parameter int W  = IdxW,
  parameter int D  = NbW,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic [W-1:0]  dividend,
  input  wire logic [D-1:0]  divisor,
  input  wire logic [SW-1:0] side_in,
  output logic               out_valid,
  output logic [W-1:0]       quotient,
  output logic [D-1:0]       remainder,
  output logic [SW-1:0]      side_out
);

  logic          v_q   [W];
  logic [W-1:0]  acc_q [W];
  logic [D-1:0]  rem_q [W];
  logic [D-1:0]  dv_q  [W];
  logic [SW-1:0] sd_q  [W];

  for (genvar k = 0; k < W; k++) begin : g_st
    logic          v_i;
    logic [W-1:0]  acc_i;
    logic [D-1:0]  rem_i;
    logic [D-1:0]  dv_i;
    logic [SW-1:0] sd_i;
    logic [D:0]    r_ext;
    logic [D:0]    r_sub;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_i   = in_valid;
      assign acc_i = dividend;
      assign rem_i = '0;
      assign dv_i  = divisor;
      assign sd_i  = side_in;
    end else begin : g_next
      assign v_i   = v_q[k-1];
      assign acc_i = acc_q[k-1];
      assign rem_i = rem_q[k-1];
      assign dv_i  = dv_q[k-1];
      assign sd_i  = sd_q[k-1];
    end

    // shift in next dividend bit, subtract when it fits
    assign r_ext = {rem_i, acc_i[W-1]};
    assign r_sub = r_ext - {1'b0, dv_i};
    assign ge    = (r_ext >= {1'b0, dv_i});

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      acc_q[k] <= {acc_i[W-2:0], ge};
      rem_q[k] <= ge ? r_sub[D-1:0] : r_ext[D-1:0];
      dv_q[k]  <= dv_i;
      sd_q[k]  <= sd_i;
    end
  end

  assign out_valid = v_q[W-1];
  assign quotient  = acc_q[W-1];
  assign remainder = rem_q[W-1];
  assign side_out  = sd_q[W-1];

endmodule
`default_nettype wire

// ===== sv/bcim_assemble.sv =====
// Assembly stages: owner rank, local row/col, leading dimension, local index.
`default_nettype none
module bcim_assemble
  import bcim_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire bcim_mid_t mid,
  input  wire bcim_cfg_t cfg,
  output logic           done,
  output bcim_out_t      result
);

  // stage 3
  logic             v3, err3, lt3, eq3;
  logic [RankW-1:0] owner3;
  logic [IdxW-1:0]  lr3, lc3, cnt3;
  logic [NbW-1:0]   remn3;
  // stage 4
  logic             v4, err4;
  logic [RankW-1:0] owner4;
  logic [IdxW-1:0]  lr4, lc4, lld4;
  // stage 5
  logic             v5, err5;
  logic [RankW-1:0] owner5;
  logic [IdxW-1:0]  lr5;
  logic [LocW-1:0]  prod5;
  // stage 6
  logic             v6;
  bcim_out_t        res6;

  logic [2*GridW-1:0] own_mul;
  logic [IdxW+NbW:0]  lr_full, lc_full;
  logic [IdxW+NbW-1:0] cnt_full;
  logic [IdxW:0]      lld_sum;
  logic [IdxW-1:0]    lld_add;
  logic [LocW:0]      idx_sum;

  assign own_mul  = mid.pr * cfg.npc;
  assign lr_full  = (IdxW+NbW+1)'(mid.qq_r * cfg.nb) + (IdxW+NbW+1)'(mid.rem_r);
  assign lc_full  = (IdxW+NbW+1)'(mid.qq_c * cfg.nb) + (IdxW+NbW+1)'(mid.rem_c);
  assign cnt_full = mid.bq * cfg.nb;

  // processes before the partial block get a full extra block, the one holding it gets its remainder
  always_comb begin
    if (lt3) begin
      lld_add = IdxW'(cfg.nb);
    end else if (eq3) begin
      lld_add = IdxW'(remn3);
    end else begin
      lld_add = '0;
    end
  end
  assign lld_sum = {1'b0, cnt3} + {1'b0, lld_add};
  assign idx_sum = {1'b0, prod5} + (LocW+1)'(lr5);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      v3 <= mid.valid;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    err3   <= mid.err;
    owner3 <= own_mul[RankW-1:0] + RankW'(mid.pc);
    lr3    <= lr_full[IdxW-1:0];
    lc3    <= lc_full[IdxW-1:0];
    cnt3   <= cnt_full[IdxW-1:0];
    lt3    <= (mid.pr < mid.extra);
    eq3    <= (mid.pr == mid.extra);
    remn3  <= mid.rem_n;

    err4   <= err3;
    owner4 <= owner3;
    lr4    <= lr3;
    lc4    <= lc3;
    lld4   <= (lld_sum[IdxW-1:0] == '0) ? IdxW'(1) : lld_sum[IdxW-1:0];

    err5   <= err4;
    owner5 <= owner4;
    lr5    <= lr4;
    prod5  <= lc4 * lld4;

    res6.owner_rank  <= owner5;
    res6.local_index <= idx_sum[LocW-1:0];
    res6.index_error <= err5;
  end

  assign done   = v6;
  assign result = res6;

  a_lld_nonzero: assert property (@(posedge clk) disable iff (rst) v4 |-> lld4 != '0)
    else $error("leading dimension is zero");
  a_valid_chain: assert property (@(posedge clk) disable iff (rst) v3 |=> ##2 v6)
    else $error("assembly valid lost");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst) v6 |-> $past(v3, 3))
    else $error("assembly valid invented");

endmodule
`default_nettype wire

// ===== sv/block_cyclic_index_map_core.sv =====
// Top level: block-cyclic owner and local index map, config registers and pipeline.
// Pipeline from the start transfer to the done strobe:
//   31 stages for g / block_size, 31 for the quotient / grid count, 4 assembly stages.
// Throughput: one coordinate pair per cycle; busy is always low.
// The receiver cannot stall; each result is shown for one cycle under done.
// Reset (rst, synchronous): empties the pipeline and loads matrix_size 1,
//   block_size 64, grid_rows 1, grid_cols 1.
`default_nettype none
module block_cyclic_index_map_core
  import bcim_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire bcim_in_t            req,
  output logic                     done,
  output bcim_out_t                result,
  input  wire logic                cfg_we,
  input  wire logic [CfgAddrW-1:0] cfg_addr,
  input  wire logic [IdxW-1:0]     cfg_wdata
);

  // configuration registers
  logic [IdxW-1:0]  matrix_size;
  logic [NbW-1:0]   block_size;
  logic [GridW-1:0] grid_rows;
  logic [GridW-1:0] grid_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= IdxW'(1);
      block_size  <= NbW'(64);
      grid_rows   <= GridW'(1);
      grid_cols   <= GridW'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MATRIX_SIZE: matrix_size <= cfg_wdata;
        REG_BLOCK_SIZE:  block_size  <= cfg_wdata[NbW-1:0];
        REG_GRID_ROWS:   grid_rows   <= cfg_wdata[GridW-1:0];
        REG_GRID_COLS:   grid_cols   <= cfg_wdata[GridW-1:0];
        default: ;   // unknown index: write dropped
      endcase
    end
  end

  // a zero block size or grid count acts as one
  logic [NbW-1:0]   nb;
  logic [GridW-1:0] npr, npc;
  assign nb  = (block_size == '0) ? NbW'(1) : block_size;
  assign npr = (grid_rows == '0) ? GridW'(1) : grid_rows;
  assign npc = (grid_cols == '0) ? GridW'(1) : grid_cols;

  // the pipeline never stalls, so a transfer happens whenever start is high
  assign busy = 1'b0;

  logic in_fire, in_err;
  assign in_fire = start && !busy;
  assign in_err  = (req.global_row >= matrix_size) || (req.global_col >= matrix_size);

  // first division: g / nb for row, column and the matrix size
  logic            v1_r, v1_c, v1_n, err1;
  logic [IdxW-1:0] q1_r, q1_c, q1_n;
  logic [NbW-1:0]  r1_r, r1_c, r1_n;

  bcim_div_pipe #(.W(IdxW), .D(NbW), .SW(1)) u_div_row1 (
    .clk, .rst, .in_valid(in_fire), .dividend(req.global_row), .divisor(nb),
    .side_in(in_err), .out_valid(v1_r), .quotient(q1_r), .remainder(r1_r), .side_out(err1)
  );
  bcim_div_pipe #(.W(IdxW), .D(NbW), .SW(1)) u_div_col1 (
    .clk, .rst, .in_valid(in_fire), .dividend(req.global_col), .divisor(nb),
    .side_in(1'b0), .out_valid(v1_c), .quotient(q1_c), .remainder(r1_c), .side_out()
  );
  bcim_div_pipe #(.W(IdxW), .D(NbW), .SW(1)) u_div_n1 (
    .clk, .rst, .in_valid(in_fire), .dividend(matrix_size), .divisor(nb),
    .side_in(1'b0), .out_valid(v1_n), .quotient(q1_n), .remainder(r1_n), .side_out()
  );

  // second division: block index / grid count gives grid coordinate and block cycle
  bcim_mid_t mid;
  logic      v2_c, v2_n;

  bcim_div_pipe #(.W(IdxW), .D(GridW), .SW(NbW+1)) u_div_row2 (
    .clk, .rst, .in_valid(v1_r), .dividend(q1_r), .divisor(npr),
    .side_in({err1, r1_r}), .out_valid(mid.valid), .quotient(mid.qq_r),
    .remainder(mid.pr), .side_out({mid.err, mid.rem_r})
  );
  bcim_div_pipe #(.W(IdxW), .D(GridW), .SW(NbW)) u_div_col2 (
    .clk, .rst, .in_valid(v1_r), .dividend(q1_c), .divisor(npc),
    .side_in(r1_c), .out_valid(v2_c), .quotient(mid.qq_c),
    .remainder(mid.pc), .side_out(mid.rem_c)
  );
  bcim_div_pipe #(.W(IdxW), .D(GridW), .SW(NbW)) u_div_n2 (
    .clk, .rst, .in_valid(v1_r), .dividend(q1_n), .divisor(npr),
    .side_in(r1_n), .out_valid(v2_n), .quotient(mid.bq),
    .remainder(mid.extra), .side_out(mid.rem_n)
  );

  bcim_cfg_t cfg;
  assign cfg.nb  = nb;
  assign cfg.npc = npc;

  bcim_assemble u_asm (
    .clk, .rst, .mid, .cfg, .done, .result
  );

  a_latency: assert property (@(posedge clk) disable iff (rst) in_fire |-> ##Latency done)
    else $error("result missing after pipeline latency");
  a_lanes1: assert property (@(posedge clk) disable iff (rst) v1_r == v1_c && v1_r == v1_n)
    else $error("first divider lanes out of step");
  a_lanes2: assert property (@(posedge clk) disable iff (rst)
                             mid.valid == v2_c && mid.valid == v2_n)
    else $error("second divider lanes out of step");

endmodule
`default_nettype wire
